@@ hw/rtl/helper_process_supervisor_fsm_macros.svh @@
// Assertion macros for the worker supervisor block.
// Used by files that carry concurrent assertions; expects a clk and rst_n in scope.
`ifndef HELPER_PROCESS_SUPERVISOR_FSM_MACROS_SVH
`define HELPER_PROCESS_SUPERVISOR_FSM_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define HPSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define HPSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hpsf_pkg.sv @@
// Types and constants shared by the worker supervisor block.
// No dependencies; compiled first.
`default_nettype none

package hpsf_pkg;

  // Mode codes
  localparam logic [1:0] MODE_INACTIVE = 2'd0;
  localparam logic [1:0] MODE_RUNNING  = 2'd1;
  localparam logic [1:0] MODE_PAUSED   = 2'd2;
  localparam logic [1:0] MODE_COOLDOWN = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_AVAILABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_TIME       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HANG_GRACE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_TIME     = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] RST_WATCHDOG_INTERVAL = 16'd5;
  localparam logic [15:0] RST_WARMUP_TIME       = 16'd60;
  localparam logic [15:0] RST_HANG_GRACE        = 16'd30;
  localparam logic [15:0] RST_COOLDOWN_TIME     = 16'd30;

  typedef struct packed {
    logic [31:0] time_seconds;
    logic        busy_req;
    logic        enable;
    logic        worker_present;
    logic        worker_responsive;
    logic        launch_ok;
  } hpsf_req_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        kill_cmd;
    logic        launch_cmd;
    logic        hang_pending;
    logic [15:0] cooldown_left;
  } hpsf_rsp_t;

  typedef struct packed {
    logic        worker_available;
    logic [15:0] watchdog_interval;
    logic [15:0] warmup_time;
    logic [15:0] hang_grace;
    logic [15:0] cooldown_time;
  } hpsf_cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        hang_flag;
    logic [31:0] last_poll_time;
    logic [31:0] launch_time;
    logic [31:0] hang_start_time;
    logic [31:0] cooldown_start_time;
  } hpsf_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/hpsf_ifs.sv @@
// Handshake channel interfaces: poll requests, results and register writes.
// Depends on hpsf_pkg for the payload types.
`default_nettype none

interface hpsf_req_if;
  logic                 valid;
  logic                 ready;
  hpsf_pkg::hpsf_req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hpsf_rsp_if;
  logic                 valid;
  logic                 ready;
  hpsf_pkg::hpsf_rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hpsf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [hpsf_pkg::CFG_IDX_W-1:0]     reg_idx;
  logic [hpsf_pkg::CFG_DATA_W-1:0]    wdata;
  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hpsf_step.sv @@
// One poll of the supervisor: next state and result from current state and request.
// Purely combinational; depends on hpsf_pkg.
`default_nettype none

module hpsf_step (
  input  wire hpsf_pkg::hpsf_cfg_t   cfg,
  input  wire hpsf_pkg::hpsf_state_t cur,
  input  wire hpsf_pkg::hpsf_req_t   req,
  output hpsf_pkg::hpsf_state_t nxt,
  output hpsf_pkg::hpsf_rsp_t   rsp
);
  import hpsf_pkg::*;

  logic [31:0] now;
  logic [31:0] d_poll;
  logic [31:0] d_launch;
  logic [31:0] d_hang;
  logic [31:0] d_cool;
  logic [31:0] el_cool;
  logic        kill;
  logic        launch;

  // Wrapping time differences against the current state
  assign now      = req.time_seconds;
  assign d_poll   = now - cur.last_poll_time;
  assign d_launch = now - cur.launch_time;
  assign d_hang   = now - cur.hang_start_time;
  assign d_cool   = now - cur.cooldown_start_time;

  // Mode transitions and command generation
  always_comb begin
    nxt    = cur;
    kill   = 1'b0;
    launch = 1'b0;
    if (cfg.worker_available) begin
      if (!req.enable) begin
        if (cur.mode != MODE_INACTIVE) begin
          kill          = req.worker_present;
          nxt.mode      = MODE_INACTIVE;
          nxt.hang_flag = 1'b0;
        end
      end else begin
        unique case (cur.mode)
          MODE_INACTIVE: begin
            if (req.busy_req) begin
              nxt.mode = MODE_PAUSED;
            end else if (req.worker_present) begin
              nxt.launch_time = now;
              nxt.mode        = MODE_RUNNING;
            end else if (req.launch_ok) begin
              launch          = 1'b1;
              nxt.launch_time = now;
              nxt.hang_flag   = 1'b0;
              nxt.mode        = MODE_RUNNING;
            end
          end
          MODE_RUNNING: begin
            if (req.busy_req) begin
              kill          = 1'b1;
              nxt.mode      = MODE_PAUSED;
              nxt.hang_flag = 1'b0;
            end else if (d_poll >= {16'd0, cfg.watchdog_interval}) begin
              nxt.last_poll_time = now;
              // watchdog skipped during warmup
              if (d_launch >= {16'd0, cfg.warmup_time}) begin
                if (!req.worker_present) begin
                  nxt.hang_flag = 1'b0;
                  if (req.launch_ok) begin
                    launch          = 1'b1;
                    nxt.launch_time = now;
                  end
                end else if (!req.worker_responsive) begin
                  if (!cur.hang_flag) begin
                    nxt.hang_flag       = 1'b1;
                    nxt.hang_start_time = now;
                  end else if (d_hang >= {16'd0, cfg.hang_grace}) begin
                    // kill, then relaunch as if absent
                    kill          = 1'b1;
                    nxt.hang_flag = 1'b0;
                    if (req.launch_ok) begin
                      launch          = 1'b1;
                      nxt.launch_time = now;
                    end
                  end
                end else begin
                  nxt.hang_flag = 1'b0;
                end
              end
            end
          end
          MODE_PAUSED: begin
            if (!req.busy_req) begin
              nxt.cooldown_start_time = now;
              nxt.mode                = MODE_COOLDOWN;
            end
          end
          MODE_COOLDOWN: begin
            if (req.busy_req) begin
              nxt.mode = MODE_PAUSED;
            end else if (d_cool >= {16'd0, cfg.cooldown_time}) begin
              if (req.worker_present) begin
                nxt.launch_time = now;
                nxt.mode        = MODE_RUNNING;
              end else if (req.launch_ok) begin
                launch          = 1'b1;
                nxt.launch_time = now;
                nxt.hang_flag   = 1'b0;
                nxt.mode        = MODE_RUNNING;
              end
            end
          end
          default: begin
            nxt = cur;
          end
        endcase
      end
    end
  end

  // Cooldown remaining, from the state after this poll
  assign el_cool = now - nxt.cooldown_start_time;

  always_comb begin
    rsp.mode          = nxt.mode;
    rsp.kill_cmd      = kill;
    rsp.launch_cmd    = launch;
    rsp.hang_pending  = nxt.hang_flag;
    rsp.cooldown_left = 16'd0;
    if ((nxt.mode == MODE_COOLDOWN) && (el_cool < {16'd0, cfg.cooldown_time})) begin
      rsp.cooldown_left = cfg.cooldown_time - el_cool[15:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/helper_process_supervisor_fsm.sv @@
// Top level of the worker supervisor: register file, poll input stage, result stage.
// Depends on hpsf_pkg, hpsf_ifs, hpsf_step and the assertion macro header.
`default_nettype none
`include "helper_process_supervisor_fsm_macros.svh"

// Worker supervisor. Each poll request carries a timestamp and the observed
// worker status; the block answers every request with exactly one result that
// holds the mode after the poll, the kill and launch commands, the hang flag
// and the seconds left in cooldown. Requests pass through an input register
// and a result register with the state update done by the step logic in
// between; a taken request is evaluated once the result register is free, and
// its result is then offered from that register. One request is taken per
// cycle when the result side keeps up; throughput is set by the single state
// update per cycle. The result register lets a new request enter while a
// finished result waits. Registers are written through the cfg channel, which
// is always ready; write them only while no request is in flight. After reset
// the worker is marked unavailable and every poll leaves the state as it is.
module helper_process_supervisor_fsm (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hpsf_req_if.sink   in_ch,
  hpsf_rsp_if.source out_ch,
  hpsf_cfg_if.sink   cfg_ch
);
  import hpsf_pkg::*;

  hpsf_cfg_t   cfg_r;
  hpsf_state_t state_r;
  hpsf_state_t state_nxt;
  hpsf_req_t   req_r;
  logic        req_vld_r;
  hpsf_rsp_t   rsp_nxt;
  hpsf_rsp_t   rsp_r;
  logic        rsp_vld_r;
  logic        rsp_free;
  logic        step_go;

  // Register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.worker_available  <= 1'b0;
      cfg_r.watchdog_interval <= RST_WATCHDOG_INTERVAL;
      cfg_r.warmup_time       <= RST_WARMUP_TIME;
      cfg_r.hang_grace        <= RST_HANG_GRACE;
      cfg_r.cooldown_time     <= RST_COOLDOWN_TIME;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_idx)
        CFG_WORKER_AVAILABLE:  cfg_r.worker_available  <= cfg_ch.wdata[0];
        CFG_WATCHDOG_INTERVAL: cfg_r.watchdog_interval <= cfg_ch.wdata;
        CFG_WARMUP_TIME:       cfg_r.warmup_time       <= cfg_ch.wdata;
        CFG_HANG_GRACE:        cfg_r.hang_grace        <= cfg_ch.wdata;
        CFG_COOLDOWN_TIME:     cfg_r.cooldown_time     <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign rsp_free    = !rsp_vld_r || out_ch.ready;
  assign step_go     = req_vld_r && rsp_free;
  assign in_ch.ready = !req_vld_r || step_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      req_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_r <= in_ch.data;
    end
  end

  // Poll evaluation
  hpsf_step u_step (
    .cfg (cfg_r),
    .cur (state_r),
    .req (req_r),
    .nxt (state_nxt),
    .rsp (rsp_nxt)
  );

  // Supervisor state, updated once per evaluated poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step_go) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_vld_r <= 1'b0;
    end else if (rsp_free) begin
      rsp_vld_r <= step_go;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_ch.valid = rsp_vld_r;
  assign out_ch.data  = rsp_r;

  // Checks
  `HPSF_ASSERT_NOW(a_hang_only_running, state_r.hang_flag, state_r.mode == MODE_RUNNING, "hang flag outside running")
  `HPSF_ASSERT_NOW(a_launch_gives_running, rsp_vld_r && rsp_r.launch_cmd, rsp_r.mode == MODE_RUNNING, "launch without running mode")
  `HPSF_ASSERT_NOW(a_left_only_cooldown, rsp_vld_r && (rsp_r.cooldown_left != 16'd0), rsp_r.mode == MODE_COOLDOWN, "cooldown time outside cooldown")
  `HPSF_ASSERT_NEXT(a_state_holds_idle, !step_go, $stable(state_r), "state changed without a poll")

endmodule

`default_nettype wire
